[rtl/kdop_pkg.sv]
// ----------------------------------------------------------------------------
// kdop_pkg
// Shared types and constants of the k-DOP hull build and query unit.
// ----------------------------------------------------------------------------
package kdop_pkg;

    // Field widths fixed by the item format
    localparam int GRAN_W      = 2;
    localparam int MODE_W      = 2;
    localparam int DIST_W      = 28;
    localparam int FLAG_W      = 2;
    localparam int OUT_TDATA_W = 32;

    // Distances of 2^24 voxel or more saturate
    localparam int D_CLIP_W = 24;

    localparam logic [DIST_W-1:0] DIST_ONES  = 28'hFFFFFFF;
    localparam logic [GRAN_W-1:0] GRAN_RESET = 2'd2;
    localparam logic [GRAN_W-1:0] GRAN_NONE  = 2'd0;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

    // Work done on each slab during a sweep
    typedef enum logic [1:0] {
        OP_INIT,
        OP_ADD,
        OP_QUERY
    } slab_op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_ROOT,
        ST_RESULT
    } seq_state_t;

    typedef struct packed {
        logic     start;
        slab_op_t op;
    } slab_ctrl_t;

    typedef struct packed {
        logic busy;
        logic outside;
        logic best_valid;
    } slab_status_t;

endpackage

[rtl/kdop_normal_gen.sv]
// ----------------------------------------------------------------------------
// kdop_normal_gen
// Steps through the lattice normals of the current granularity, one a cycle.
// ----------------------------------------------------------------------------
module kdop_normal_gen #(
    parameter int MAX_NORMALS = 109,
    parameter int COEF_W      = 3,
    parameter int LEN_W       = 5,
    parameter int IDX_W       = 7
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [kdop_pkg::GRAN_W-1:0] gran,
    output logic                       n_valid,
    output logic signed [COEF_W-1:0]   n_a,
    output logic signed [COEF_W-1:0]   n_b,
    output logic signed [COEF_W-1:0]   n_c,
    output logic [IDX_W-1:0]           n_idx,
    output logic [LEN_W-1:0]           n_len
);
    import kdop_pkg::*;

    localparam int SQ_W = 2 * COEF_W;

    logic                     active_reg, active_next;
    logic signed [COEF_W-1:0] a_reg, a_next;
    logic signed [COEF_W-1:0] b_reg, b_next;
    logic signed [COEF_W-1:0] c_reg, c_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [GRAN_W-1:0]        g_reg, g_next;

    logic signed [COEF_W-1:0] gs;
    logic signed [COEF_W-1:0] abs_a, abs_b;
    logic                     edge_ab;
    logic                     at_end;
    logic signed [SQ_W-1:0]   aa, bb, cc;

    // Granularity as a signed coefficient bound
    assign gs = signed'(COEF_W'(g_reg));

    // Walk the lexicographic order, skipping entries that are not normals
    always_comb
    begin
        active_next = active_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        idx_next    = idx_reg;
        g_next      = g_reg;
        abs_a       = (a_reg < 0) ? -a_reg : a_reg;
        abs_b       = (b_reg < 0) ? -b_reg : b_reg;
        edge_ab     = (abs_a == gs) || (abs_b == gs);
        at_end      = ((a_reg == gs) && (b_reg == gs) && (c_reg == gs)) ||
                      (idx_reg == IDX_W'(MAX_NORMALS - 1));
        if (start)
        begin
            active_next = 1'b1;
            g_next      = gran;
            a_next      = '0;
            b_next      = '0;
            c_next      = signed'(COEF_W'(gran));
            idx_next    = '0;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + IDX_W'(1);
            if (at_end)
            begin
                active_next = 1'b0;
            end
            if (c_reg < gs)
            begin
                c_next = edge_ab ? (c_reg + COEF_W'(1)) : gs;
            end
            else if (b_reg < gs)
            begin
                b_next = b_reg + COEF_W'(1);
                c_next = -gs;
            end
            else
            begin
                a_next = a_reg + COEF_W'(1);
                b_next = -gs;
                c_next = -gs;
            end
        end
    end

    // Hold walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        idx_reg <= idx_next;
        g_reg   <= g_next;
    end

    // Squared length of the current normal
    always_comb
    begin
        aa = SQ_W'(a_reg) * SQ_W'(a_reg);
        bb = SQ_W'(b_reg) * SQ_W'(b_reg);
        cc = SQ_W'(c_reg) * SQ_W'(c_reg);
    end

    assign n_valid = active_reg;
    assign n_a     = a_reg;
    assign n_b     = b_reg;
    assign n_c     = c_reg;
    assign n_idx   = idx_reg;
    assign n_len   = LEN_W'(unsigned'(aa + bb + cc));

endmodule

[rtl/kdop_slab_unit.sv]
// ----------------------------------------------------------------------------
// kdop_slab_unit
// Projection, slab store and compare pipeline shared by build and query.
// ----------------------------------------------------------------------------
module kdop_slab_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int MAX_NORMALS = 109,
    parameter int COEF_W      = 3,
    parameter int LEN_W       = 5,
    parameter int IDX_W       = 7,
    parameter int PROJ_W      = 21,
    parameter int DC_W        = 22
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  kdop_pkg::slab_ctrl_t           ctrl,
    input  logic signed [COORD_WIDTH-1:0]  px,
    input  logic signed [COORD_WIDTH-1:0]  py,
    input  logic signed [COORD_WIDTH-1:0]  pz,
    input  logic                           n_valid,
    input  logic signed [COEF_W-1:0]       n_a,
    input  logic signed [COEF_W-1:0]       n_b,
    input  logic signed [COEF_W-1:0]       n_c,
    input  logic [IDX_W-1:0]               n_idx,
    input  logic [LEN_W-1:0]               n_len,
    output kdop_pkg::slab_status_t         status,
    output logic [2*DC_W-1:0]              best_d2,
    output logic [LEN_W-1:0]               best_len
);
    import kdop_pkg::*;

    localparam int D_W    = PROJ_W + 1;
    localparam int D2_W   = 2 * DC_W;
    localparam int PROD_W = D2_W + LEN_W;

    // Slab store: max projection in the upper half, min in the lower
    logic [2*PROJ_W-1:0] mem [MAX_NORMALS];
    logic [2*PROJ_W-1:0] rd_reg;

    slab_op_t op_reg, op_next;

    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic [LEN_W-1:0]         s1_len_reg;
    logic signed [PROJ_W-1:0] s1_proj_reg;

    logic                     s2_valid_reg, s2_valid_next;
    logic [DC_W-1:0]          s2_d_reg;
    logic [LEN_W-1:0]         s2_len_reg;

    logic                     s3_valid_reg;
    logic [D2_W-1:0]          s3_d2_reg;
    logic [LEN_W-1:0]         s3_len_reg;

    logic                     best_valid_reg, best_valid_next;
    logic [D2_W-1:0]          best_d2_reg;
    logic [LEN_W-1:0]         best_len_reg;
    logic                     outside_reg, outside_next;

    logic signed [PROJ_W-1:0] proj_next;
    logic signed [PROJ_W-1:0] mn, mx;
    logic                     below, above;
    logic                     wr_en;
    logic [2*PROJ_W-1:0]      wr_data;
    logic [D_W-1:0]           d_lo, d_hi, d_min;
    logic                     d_sat;
    logic [PROD_W-1:0]        lhs, rhs;
    logic                     better;

    // Stage 1: project the point onto the normal
    always_comb
    begin
        proj_next = PROJ_W'(n_a) * PROJ_W'(px) +
                    PROJ_W'(n_b) * PROJ_W'(py) +
                    PROJ_W'(n_c) * PROJ_W'(pz);
    end

    // Stage 2: compare against the stored slab
    always_comb
    begin
        mn      = signed'(rd_reg[PROJ_W-1:0]);
        mx      = signed'(rd_reg[2*PROJ_W-1:PROJ_W]);
        below   = s1_proj_reg < mn;
        above   = s1_proj_reg > mx;
        wr_en   = s1_valid_reg && ((op_reg == OP_INIT) || (op_reg == OP_ADD));
        if (op_reg == OP_INIT)
        begin
            wr_data = {s1_proj_reg, s1_proj_reg};
        end
        else
        begin
            wr_data = {(above ? s1_proj_reg : mx), (below ? s1_proj_reg : mn)};
        end
        d_lo  = unsigned'(D_W'(s1_proj_reg) - D_W'(mn));
        d_hi  = unsigned'(D_W'(mx) - D_W'(s1_proj_reg));
        d_min = (d_lo < d_hi) ? d_lo : d_hi;
        d_sat = (d_min >> DC_W) != '0;
        s2_valid_next = s1_valid_reg && (op_reg == OP_QUERY) && !below && !above &&
                        !d_sat;
        op_next      = op_reg;
        outside_next = outside_reg;
        if (ctrl.start)
        begin
            op_next      = ctrl.op;
            outside_next = 1'b0;
        end
        else if (s1_valid_reg && (op_reg == OP_QUERY) && (below || above))
        begin
            outside_next = 1'b1;
        end
    end

    // Stage 4: keep the normal with the least d^2 / |n|^2
    always_comb
    begin
        lhs    = PROD_W'(s3_d2_reg) * PROD_W'(best_len_reg);
        rhs    = PROD_W'(best_d2_reg) * PROD_W'(s3_len_reg);
        better = s3_valid_reg && (!best_valid_reg || (lhs < rhs));
        best_valid_next = best_valid_reg;
        if (ctrl.start)
        begin
            best_valid_next = 1'b0;
        end
        else if (better)
        begin
            best_valid_next = 1'b1;
        end
    end

    // Read and write the slab store
    always_ff @(posedge clk)
    begin
        if (n_valid)
        begin
            rd_reg <= mem[n_idx];
        end
        if (wr_en)
        begin
            mem[s1_idx_reg] <= wr_data;
        end
    end

    // Advance pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg         <= OP_INIT;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            outside_reg    <= 1'b0;
        end
        else
        begin
            op_reg         <= op_next;
            s1_valid_reg   <= n_valid;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s2_valid_reg;
            best_valid_reg <= best_valid_next;
            outside_reg    <= outside_next;
        end
    end

    // Advance pipeline payload
    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= n_idx;
        s1_len_reg  <= n_len;
        s1_proj_reg <= proj_next;
        s2_d_reg    <= d_min[DC_W-1:0];
        s2_len_reg  <= s1_len_reg;
        s3_d2_reg   <= D2_W'(s2_d_reg) * D2_W'(s2_d_reg);
        s3_len_reg  <= s2_len_reg;
        if (better)
        begin
            best_d2_reg  <= s3_d2_reg;
            best_len_reg <= s3_len_reg;
        end
    end

    assign status.busy       = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.outside    = outside_reg;
    assign status.best_valid = best_valid_reg;
    assign best_d2           = best_d2_reg;
    assign best_len          = best_len_reg;

endmodule

[rtl/kdop_isqrt.sv]
// ----------------------------------------------------------------------------
// kdop_isqrt
// Bit-serial root: largest q with q^2 * len <= d2 * 2^16, one bit a cycle.
// ----------------------------------------------------------------------------
module kdop_isqrt #(
    parameter int DC_W  = 22,
    parameter int LEN_W = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*DC_W-1:0]    d2,
    input  logic [LEN_W-1:0]     len,
    output logic                 done,
    output logic [DC_W+7:0]      root
);
    import kdop_pkg::*;

    localparam int Q_W   = DC_W + 8;
    localparam int NW    = 2 * Q_W;
    localparam int TW    = NW + 1 + LEN_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NW-1:0]    rem_reg, rem_next;
    logic [NW-1:0]    r_reg, r_next;
    logic [NW-1:0]    step_reg, step_next;
    logic [LEN_W-1:0] len_reg, len_next;

    logic [NW:0]      trial;
    logic [TW-1:0]    cost;
    logic             take;

    // One root bit per cycle: try (q + 2^k)^2 * len against the remainder
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        r_next    = r_reg;
        step_next = step_reg;
        len_next  = len_reg;
        trial     = (NW + 1)'(r_reg) + (NW + 1)'(step_reg);
        cost      = TW'(trial) * TW'(len_reg);
        take      = cost <= TW'(rem_reg);
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNT_W'(Q_W);
            rem_next  = {d2, 16'b0};
            r_next    = '0;
            step_next = NW'(1) << (NW - 2);
            len_next  = len;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                rem_next = rem_reg - cost[NW-1:0];
                r_next   = (r_reg >> 1) + step_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            step_next = step_reg >> 2;
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        r_reg    <= r_next;
        step_reg <= step_next;
        len_reg  <= len_next;
    end

    assign done = done_reg;
    assign root = r_reg[Q_W-1:0];

endmodule

[rtl/kdop_hull_build_and_query_unit.sv]
// ----------------------------------------------------------------------------
// kdop_hull_build_and_query_unit
// k-DOP hull of 3-D integer points: build the slabs, then query points.
// ----------------------------------------------------------------------------
// One item at a time. Every item of mode 0 or 1, and every query on a loaded
// hull, walks the N lattice normals of the current granularity (N = 13, 49
// or 109 for granularity 1, 2, 3) through one projection and slab compare
// pipeline, one normal a cycle, at a pace set by the normal sequencer and the
// single port pair of the slab store. A query for a point that lies inside
// a loaded hull then adds one bit-serial root. A query on an empty hull goes
// straight to the result, and a mode 3 item starts no sweep. The result sits
// in an output register, so the next item is taken while a result waits. No
// clearing pass runs after reset.
// ----------------------------------------------------------------------------
module kdop_hull_build_and_query_unit #(
    parameter int MAX_GRANULARITY = 3,
    parameter int MAX_NORMALS     = 109,
    parameter int COORD_WIDTH     = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write: granularity
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kdop_pkg::GRAN_W-1:0]           cfg_data,
    // input items
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // s_tdata: point_x, point_y, point_z
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
    // s_tuser: mode
    input  logic [kdop_pkg::MODE_W-1:0]           s_tuser,
    // result items
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // m_tdata: distance
    output logic [kdop_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // m_tuser: inside_res, hull_empty
    output logic [kdop_pkg::FLAG_W-1:0]           m_tuser
);
    import kdop_pkg::*;

    localparam int G_TOP  = (MAX_GRANULARITY >= 3) ? 3 : 2;
    localparam int COEF_W = $clog2(G_TOP + 1) + 1;
    localparam int LEN_W  = $clog2(3 * G_TOP * G_TOP + 1);
    localparam int IDX_W  = $clog2(MAX_NORMALS);
    localparam int PROJ_W = COORD_WIDTH + $clog2(3 * G_TOP) + 1;
    localparam int D_W    = PROJ_W + 1;
    localparam int DC_W   = (D_W > D_CLIP_W) ? D_CLIP_W : D_W;
    localparam int Q_W    = DC_W + 8;

    seq_state_t                state_reg, state_next;
    logic [GRAN_W-1:0]         g_reg, g_next;
    logic                      have_reg, have_next;
    slab_op_t                  op_reg, op_next;
    logic signed [COORD_WIDTH-1:0] px_reg, px_next;
    logic signed [COORD_WIDTH-1:0] py_reg, py_next;
    logic signed [COORD_WIDTH-1:0] pz_reg, pz_next;
    logic                      res_inside_reg, res_inside_next;
    logic                      res_empty_reg, res_empty_next;
    logic [DIST_W-1:0]         res_dist_reg, res_dist_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [FLAG_W-1:0]         m_tuser_reg, m_tuser_next;
    logic [DIST_W-1:0]         m_dist_reg, m_dist_next;

    logic                      in_accept;
    logic                      cfg_accept;
    logic                      gen_start;
    logic                      root_start;
    logic                      out_load;
    slab_ctrl_t                slab_ctrl;
    slab_status_t              slab_status;

    logic                      n_valid;
    logic signed [COEF_W-1:0]  n_a, n_b, n_c;
    logic [IDX_W-1:0]          n_idx;
    logic [LEN_W-1:0]          n_len;
    logic [2*DC_W-1:0]         best_d2;
    logic [LEN_W-1:0]          best_len;
    logic                      root_done;
    logic [Q_W-1:0]            root;
    logic [63:0]               root_wide;
    logic [DIST_W-1:0]         root_dist;

    // Configuration first, items only when no write is pending
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign in_accept  = s_tvalid && s_tready;

    // Saturate the root to the distance field
    assign root_wide = 64'(root);
    assign root_dist = (root_wide > 64'(DIST_ONES)) ? DIST_ONES : root_wide[DIST_W-1:0];

    // Sequencer: next state and control
    always_comb
    begin
        state_next      = state_reg;
        g_next          = g_reg;
        have_next       = have_reg;
        op_next         = op_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pz_next         = pz_reg;
        res_inside_next = res_inside_reg;
        res_empty_next  = res_empty_reg;
        res_dist_next   = res_dist_reg;
        gen_start       = 1'b0;
        root_start      = 1'b0;
        out_load        = 1'b0;
        slab_ctrl.start = 1'b0;
        slab_ctrl.op    = op_reg;

        // Take a new granularity and empty the hull
        if (cfg_accept && (cfg_data != GRAN_NONE) &&
            (int'(cfg_data) <= MAX_GRANULARITY) && (cfg_data != g_reg))
        begin
            g_next    = cfg_data;
            have_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    px_next = signed'(s_tdata[COORD_WIDTH-1:0]);
                    py_next = signed'(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);
                    pz_next = signed'(s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]);
                    case (s_tuser)
                        MODE_START:
                        begin
                            op_next = OP_INIT;
                        end
                        MODE_ADD:
                        begin
                            op_next = have_reg ? OP_ADD : OP_INIT;
                        end
                        MODE_QUERY:
                        begin
                            op_next = OP_QUERY;
                        end
                        default:
                        begin
                            op_next = op_reg;
                        end
                    endcase
                    if (s_tuser == MODE_QUERY && !have_reg)
                    begin
                        res_inside_next = 1'b0;
                        res_empty_next  = 1'b1;
                        res_dist_next   = DIST_ONES;
                        state_next      = ST_RESULT;
                    end
                    else if (s_tuser != MODE_NONE)
                    begin
                        gen_start       = 1'b1;
                        slab_ctrl.start = 1'b1;
                        slab_ctrl.op    = op_next;
                        if (op_next == OP_INIT)
                        begin
                            have_next = 1'b1;
                        end
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                // Wait for the walk and the pipeline to drain
                if (!n_valid && !slab_status.busy)
                begin
                    if (op_reg != OP_QUERY)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (slab_status.outside || !slab_status.best_valid)
                    begin
                        res_inside_next = !slab_status.outside;
                        res_empty_next  = 1'b0;
                        res_dist_next   = DIST_ONES;
                        state_next      = ST_RESULT;
                    end
                    else
                    begin
                        root_start = 1'b1;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT:
            begin
                if (root_done)
                begin
                    res_inside_next = 1'b1;
                    res_empty_next  = 1'b0;
                    res_dist_next   = root_dist;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                // Hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        m_tuser_next = m_tuser_reg;
        m_dist_next  = m_dist_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = {res_empty_reg, res_inside_reg};
            m_dist_next   = res_dist_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            g_reg        <= GRAN_RESET;
            have_reg     <= 1'b0;
            op_reg       <= OP_INIT;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            g_reg        <= g_next;
            have_reg     <= have_next;
            op_reg       <= op_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Hold item payload
    always_ff @(posedge clk)
    begin
        px_reg         <= px_next;
        py_reg         <= py_next;
        pz_reg         <= pz_next;
        res_inside_reg <= res_inside_next;
        res_empty_reg  <= res_empty_next;
        res_dist_reg   <= res_dist_next;
        m_tuser_reg    <= m_tuser_next;
        m_dist_reg     <= m_dist_next;
    end

    kdop_normal_gen #(
        .MAX_NORMALS (MAX_NORMALS),
        .COEF_W      (COEF_W),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W)
    ) u_normal_gen (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (gen_start),
        .gran    (g_reg),
        .n_valid (n_valid),
        .n_a     (n_a),
        .n_b     (n_b),
        .n_c     (n_c),
        .n_idx   (n_idx),
        .n_len   (n_len)
    );

    kdop_slab_unit #(
        .COORD_WIDTH (COORD_WIDTH),
        .MAX_NORMALS (MAX_NORMALS),
        .COEF_W      (COEF_W),
        .LEN_W       (LEN_W),
        .IDX_W       (IDX_W),
        .PROJ_W      (PROJ_W),
        .DC_W        (DC_W)
    ) u_slab_unit (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (slab_ctrl),
        .px       (px_reg),
        .py       (py_reg),
        .pz       (pz_reg),
        .n_valid  (n_valid),
        .n_a      (n_a),
        .n_b      (n_b),
        .n_c      (n_c),
        .n_idx    (n_idx),
        .n_len    (n_len),
        .status   (slab_status),
        .best_d2  (best_d2),
        .best_len (best_len)
    );

    kdop_isqrt #(
        .DC_W  (DC_W),
        .LEN_W (LEN_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .d2    (best_d2),
        .len   (best_len),
        .done  (root_done),
        .root  (root)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = OUT_TDATA_W'(m_dist_reg);

    // A result appears only out of the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("result item without a finished item");

    // An inside point never comes from an empty hull
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> !(m_tuser_reg[0] && m_tuser_reg[1]))
        else $error("inside and empty flagged together");

    // Outside or empty results carry a saturated distance
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tuser_reg[0]) |-> m_dist_reg == DIST_ONES)
        else $error("outside result with finite distance");

    // The root runs only on a candidate slab
    assert property (@(posedge clk) disable iff (!rst_n)
        root_start |-> (slab_status.best_valid && !slab_status.outside))
        else $error("root started without a candidate");

endmodule
